// ----- design/caseless_substring_search_macros.svh -----
// Assertion macros for the caseless substring search block.
`ifndef CASELESS_SUBSTRING_SEARCH_MACROS_SVH
`define CASELESS_SUBSTRING_SEARCH_MACROS_SVH

// same-cycle implication, held off during reset
`define CSS_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, held off during reset
`define CSS_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- design/css_pkg.sv -----
// Shared types, constants and the case-folding function of the substring search.
`default_nettype none

package css_pkg;

   localparam int unsigned NEEDLE_MAX_DEFAULT = 16;
   localparam int unsigned CHAR_W             = 8;
   localparam int unsigned LEN_W              = 5;
   localparam int unsigned CSR_DATA_W         = 64;
   localparam int unsigned CSR_IDX_W          = 2;
   localparam int unsigned CHARS_PER_REG      = CSR_DATA_W / CHAR_W;
   localparam int unsigned CHARS_IN_REGS      = 2 * CHARS_PER_REG;

   localparam logic [CHAR_W-1:0] UPPER_FIRST = 8'h41;
   localparam logic [CHAR_W-1:0] UPPER_LAST  = 8'h5A;
   localparam logic [CHAR_W-1:0] CASE_OFFSET = 8'h20;

   typedef enum logic [CSR_IDX_W-1:0] {
      REG_NEEDLE_LOW    = 2'd0,
      REG_NEEDLE_HIGH   = 2'd1,
      REG_NEEDLE_LENGTH = 2'd2,
      REG_IGNORE_CASE   = 2'd3
   } csr_reg_type;

   // broadcast to every cell
   typedef struct packed {
      logic              step;
      logic              last;
      logic [CHAR_W-1:0] folded_char;
      logic              ignore_case;
      logic [LEN_W-1:0]  needle_length;
   } cell_ctrl_type;

   // needle character write into one cell
   typedef struct packed {
      logic              we;
      logic [CHAR_W-1:0] data;
   } cell_wr_type;

   function automatic logic [CHAR_W-1:0] fold(input logic [CHAR_W-1:0] c,
                                              input logic              ic);
      logic [CHAR_W-1:0] r;
      r = c;
      if (ic && (c >= UPPER_FIRST) && (c <= UPPER_LAST)) begin
         r = c + CASE_OFFSET;
      end
      return r;
   endfunction

endpackage

`default_nettype wire

// ----- design/css_channels.sv -----
// Handshake channel interfaces: haystack items, result items and register writes.
`default_nettype none

interface css_req_if;
   logic                      valid;
   logic                      ready;
   logic [css_pkg::CHAR_W-1:0] haystack_char;
   logic                      haystack_last;

   modport source (output valid, output haystack_char, output haystack_last, input ready);
   modport sink   (input valid, input haystack_char, input haystack_last, output ready);
endinterface

interface css_rsp_if;
   logic valid;
   logic ready;
   logic match_ends_here;
   logic found_so_far;
   logic result_last;

   modport source (output valid, output match_ends_here, output found_so_far,
                   output result_last, input ready);
   modport sink   (input valid, input match_ends_here, input found_so_far,
                   input result_last, output ready);
endinterface

interface css_csr_if;
   logic                          valid;
   logic                          ready;
   logic [css_pkg::CSR_IDX_W-1:0]  index;
   logic [css_pkg::CSR_DATA_W-1:0] wdata;

   modport source (output valid, output index, output wdata, input ready);
   modport sink   (input valid, input index, input wdata, output ready);
endinterface

`default_nettype wire

// ----- design/caseless_substring_search.sv -----
// Streaming substring search top level: a chain of needle cells, one per needle position.
// Result: registered, valid in the cycle after its character is accepted.
// Throughput: one character per cycle; the single output register is refilled in the
// cycle it is taken, so the chain steps whenever the result side is ready or empty.
// Reset clears the needle, length, case mode, prefix bits and found flag at once.
`default_nettype none

module caseless_substring_search #(
   parameter int unsigned NEEDLE_MAX = css_pkg::NEEDLE_MAX_DEFAULT
) (
   input wire logic clock,
   input wire logic reset,
   css_req_if.sink   req_port,
   css_rsp_if.source rsp_port,
   css_csr_if.sink   csr_port
);

   css_pkg::cell_ctrl_type            ctrl;
   css_pkg::cell_wr_type [NEEDLE_MAX-1:0] cell_wr;
   logic [NEEDLE_MAX-1:0]             chain_bits;
   logic [NEEDLE_MAX-1:0]             taps;

   logic [css_pkg::LEN_W-1:0] needle_length_ff;
   logic [css_pkg::LEN_W-1:0] needle_length_in;
   logic                      ignore_case_ff;
   logic                      ignore_case_in;
   logic                      found_ff;
   logic                      found_in;

   logic rsp_valid_ff;
   logic rsp_valid_in;
   logic match_ff;
   logic match_in;
   logic found_out_ff;
   logic found_out_in;
   logic last_ff;
   logic last_in;

   logic step;
   logic hit;
   logic found_next;
   logic csr_fire;

   assign csr_port.ready = 1'b1;
   assign csr_fire       = csr_port.valid & csr_port.ready;

   assign req_port.ready = ~rsp_valid_ff | rsp_port.ready;
   assign step           = req_port.valid & req_port.ready;

   assign ctrl.step          = step;
   assign ctrl.last          = req_port.haystack_last;
   assign ctrl.folded_char   = css_pkg::fold(req_port.haystack_char, ignore_case_ff);
   assign ctrl.ignore_case   = ignore_case_ff;
   assign ctrl.needle_length = needle_length_ff;

   genvar gi;
   generate
      for (gi = 0; gi < NEEDLE_MAX; gi++) begin : g_cell
         logic prev_bit;

         if (gi == 0) begin : g_head
            assign prev_bit = 1'b1;
         end else begin : g_link
            assign prev_bit = chain_bits[gi-1];
         end

         if (gi < css_pkg::CHARS_PER_REG) begin : g_low
            assign cell_wr[gi].we   = csr_fire &&
                                      (csr_port.index == css_pkg::REG_NEEDLE_LOW);
            assign cell_wr[gi].data = csr_port.wdata[css_pkg::CHAR_W*gi +: css_pkg::CHAR_W];
         end else if (gi < css_pkg::CHARS_IN_REGS) begin : g_high
            assign cell_wr[gi].we   = csr_fire &&
                                      (csr_port.index == css_pkg::REG_NEEDLE_HIGH);
            assign cell_wr[gi].data = csr_port.wdata[css_pkg::CHAR_W*(gi -
                                      css_pkg::CHARS_PER_REG) +: css_pkg::CHAR_W];
         end else begin : g_none
            assign cell_wr[gi].we   = 1'b0;
            assign cell_wr[gi].data = '0;
         end

         css_cell #(
            .POS(gi)
         ) u_cell (
            .clock    (clock),
            .reset    (reset),
            .ctrl     (ctrl),
            .wr       (cell_wr[gi]),
            .prev_bit (prev_bit),
            .bit_out  (chain_bits[gi]),
            .tap      (taps[gi])
         );
      end
   endgenerate

   assign hit        = (needle_length_ff == '0) | (|taps);
   assign found_next = found_ff | hit;

   always_comb begin
      needle_length_in = needle_length_ff;
      ignore_case_in   = ignore_case_ff;
      if (csr_fire) begin
         case (csr_port.index)
            css_pkg::REG_NEEDLE_LENGTH: begin
               needle_length_in = csr_port.wdata[css_pkg::LEN_W-1:0];
            end
            css_pkg::REG_IGNORE_CASE: begin
               ignore_case_in = csr_port.wdata[0];
            end
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      found_in     = found_ff;
      rsp_valid_in = rsp_valid_ff;
      match_in     = match_ff;
      found_out_in = found_out_ff;
      last_in      = last_ff;
      if (rsp_port.ready) begin
         rsp_valid_in = 1'b0;
      end
      if (step) begin
         found_in     = req_port.haystack_last ? 1'b0 : found_next;
         rsp_valid_in = 1'b1;
         match_in     = hit;
         found_out_in = found_next;
         last_in      = req_port.haystack_last;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         needle_length_ff <= '0;
         ignore_case_ff   <= 1'b0;
         found_ff         <= 1'b0;
         rsp_valid_ff     <= 1'b0;
      end else begin
         needle_length_ff <= needle_length_in;
         ignore_case_ff   <= ignore_case_in;
         found_ff         <= found_in;
         rsp_valid_ff     <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      match_ff     <= match_in;
      found_out_ff <= found_out_in;
      last_ff      <= last_in;
   end

   assign rsp_port.valid           = rsp_valid_ff;
   assign rsp_port.match_ends_here = match_ff;
   assign rsp_port.found_so_far    = found_out_ff;
   assign rsp_port.result_last     = last_ff;

`include "caseless_substring_search_macros.svh"

   `CSS_ASSERT_NOW(a_match_sets_found, clock, reset, rsp_valid_ff && match_ff, found_out_ff, "match without found")
   `CSS_ASSERT_NOW(a_free_output_takes_item, clock, reset, !rsp_valid_ff, req_port.ready, "input stalled with empty output register")
   `CSS_ASSERT_NEXT(a_last_clears_state, clock, reset, step && req_port.haystack_last, !found_ff && (chain_bits == '0), "state not cleared after last item")
   `CSS_ASSERT_NEXT(a_empty_needle_hits, clock, reset, step && (needle_length_ff == '0), rsp_valid_ff && match_ff, "empty needle did not match")

endmodule

`default_nettype wire

// ----- design/css_cell.sv -----
// One needle position: holds its needle character and its prefix-match bit.
`default_nettype none

module css_cell #(
   parameter int unsigned POS = 0
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire css_pkg::cell_ctrl_type ctrl,
   input  wire css_pkg::cell_wr_type   wr,
   input  wire logic                   prev_bit,
   output logic                        bit_out,
   output logic                        tap
);

   logic [css_pkg::CHAR_W-1:0] needle_char_ff;
   logic [css_pkg::CHAR_W-1:0] needle_char_in;
   logic                       prefix_ff;
   logic                       prefix_in;
   logic                       char_eq;
   logic                       next_bit;

   assign char_eq  = (css_pkg::fold(needle_char_ff, ctrl.ignore_case) == ctrl.folded_char);
   assign next_bit = prev_bit & char_eq;
   assign tap      = next_bit & (32'(ctrl.needle_length) == 32'(POS + 1));
   assign bit_out  = prefix_ff;

   always_comb begin
      needle_char_in = needle_char_ff;
      if (wr.we) begin
         needle_char_in = wr.data;
      end
   end

   always_comb begin
      prefix_in = prefix_ff;
      if (ctrl.step) begin
         prefix_in = ctrl.last ? 1'b0 : next_bit;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         needle_char_ff <= '0;
         prefix_ff      <= 1'b0;
      end else begin
         needle_char_ff <= needle_char_in;
         prefix_ff      <= prefix_in;
      end
   end

endmodule

`default_nettype wire
